>>> src/tlvcc_pkg.sv
// Shared types and constants for the TLV container checker.
// No dependencies; imported by every module of the block.
package tlvcc_pkg;

  localparam int unsigned OffW   = 24;
  localparam int unsigned CountW = 9;

  localparam logic [15:0]       FIRST_TYPE    = 16'h8000;
  localparam logic [15:0]       END_TYPE      = 16'h8f00;
  localparam logic [15:0]       MIN_FIRST_LEN = 16'd4;
  localparam logic [OffW-1:0]   OFFSET_MAX    = 24'hFFFFFF;

  localparam logic [31:0]       MAGIC_RST     = 32'h57464d4d;
  localparam logic [OffW-1:0]   SIZE_RST      = 24'd2097152;
  localparam logic [CountW-1:0] RECORDS_RST   = 9'd256;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_SIZE    = 2'd1,
    REG_RECORDS = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_PASS      = 3'd0,
    ST_BAD_FIRST = 3'd1,
    ST_OVER_SIZE = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_NO_END    = 3'd5
  } status_e;

  typedef struct packed {
    logic [31:0]       expected_magic;
    logic [OffW-1:0]   size_limit;
    logic [CountW-1:0] record_limit;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [OffW-1:0]   end_offset;
    logic [CountW-1:0] record_count;
  } res_t;

endpackage

>>> src/tlvcc_cfg_regs.sv
// Configuration register bank of the TLV container checker.
// Depends on tlvcc_pkg for the register indexes, reset values and the cfg_t bundle.
module tlvcc_cfg_regs import tlvcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [1:0]  wr_index_i,
  input  logic [31:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_magic <= MAGIC_RST;
      cfg_q.size_limit     <= SIZE_RST;
      cfg_q.record_limit   <= RECORDS_RST;
    end else if (wr_en_i) begin
      case (wr_index_i)
        REG_MAGIC:   cfg_q.expected_magic <= wr_data_i;
        REG_SIZE:    cfg_q.size_limit     <= wr_data_i[OffW-1:0];
        REG_RECORDS: cfg_q.record_limit   <= wr_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/tlvcc_core.sv
// Check state and per-word step logic of the TLV container checker.
// Depends on tlvcc_pkg; one word is consumed in every cycle that step_i is high.
module tlvcc_core import tlvcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [1:0] cmd_i,
  input  logic [7:0] data_byte_i,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_MAGIC   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [23:0]       hdr_q, hdr_d;
  logic [23:0]       magic_q, magic_d;
  logic [1:0]        bif_q, bif_d;
  logic [15:0]       left_q, left_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [CountW-1:0] rec_q, rec_d;
  logic              verdict_q, verdict_d;

  logic [OffW-1:0]   off_inc;
  logic [1:0]        bif_inc;
  logic [CountW-1:0] rec_inc;
  logic              limit_hit;
  logic [31:0]       hdr_word;
  logic [31:0]       magic_word;
  logic [15:0]       rec_type;
  logic [15:0]       rec_len;
  logic [OffW:0]     end_sum;
  logic              over_size;
  logic [15:0]       left_dec;
  logic [15:0]       left_nxt;
  logic              finish;

  assign off_inc    = (off_q == OFFSET_MAX) ? off_q : off_q + 24'd1;
  assign bif_inc    = bif_q + 2'd1;
  assign rec_inc    = rec_q + 9'd1;
  assign limit_hit  = rec_q >= cfg_i.record_limit;
  assign hdr_word   = {data_byte_i, hdr_q};
  assign magic_word = {data_byte_i, magic_q};
  assign rec_type   = hdr_word[15:0];
  assign rec_len    = hdr_word[31:16];
  assign end_sum    = {1'b0, off_inc} + {{(OffW-15){1'b0}}, rec_len};
  assign over_size  = end_sum > {1'b0, cfg_i.size_limit};
  assign left_dec   = left_q - 16'd1;
  assign left_nxt   = (left_q != 16'd0) ? left_dec : 16'd0;

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    magic_d   = magic_q;
    bif_d     = bif_q;
    left_d    = left_q;
    off_d     = off_q;
    rec_d     = rec_q;
    verdict_d = verdict_q;
    finish    = 1'b0;
    res_o     = '{valid: 1'b0, status: ST_PASS, end_offset: off_q, record_count: rec_q};

    if (step_i) begin
      case (cmd_i)
        CMD_START: begin
          phase_d   = PH_HEADER;
          hdr_d     = '0;
          magic_d   = '0;
          bif_d     = '0;
          left_d    = '0;
          off_d     = '0;
          rec_d     = '0;
          verdict_d = 1'b0;
        end
        CMD_END: begin
          if (!verdict_q) begin
            res_o.valid  = 1'b1;
            res_o.status = (phase_q == PH_HEADER && bif_q == 2'd0 && limit_hit)
                           ? ST_NO_END : ST_TRUNCATED;
            verdict_d    = 1'b1;
          end
        end
        CMD_DATA: begin
          if (!verdict_q) begin
            case (phase_q)
              PH_HEADER: begin
                if (bif_q == 2'd0 && limit_hit) begin
                  // limit reached before a new header: fail without consuming
                  res_o.valid  = 1'b1;
                  res_o.status = ST_NO_END;
                  verdict_d    = 1'b1;
                end else begin
                  off_d = off_inc;
                  bif_d = bif_inc;
                  case (bif_q)
                    2'd0: hdr_d[7:0]   = data_byte_i;
                    2'd1: hdr_d[15:8]  = data_byte_i;
                    2'd2: hdr_d[23:16] = data_byte_i;
                    default: begin
                      res_o.end_offset = off_inc;
                      if (rec_q == '0 &&
                          (rec_type != FIRST_TYPE || rec_len < MIN_FIRST_LEN)) begin
                        res_o.valid  = 1'b1;
                        res_o.status = ST_BAD_FIRST;
                        verdict_d    = 1'b1;
                      end else if (rec_type == END_TYPE) begin
                        res_o.valid      = 1'b1;
                        res_o.status     = ST_PASS;
                        res_o.end_offset = off_inc - 24'd4;
                        verdict_d        = 1'b1;
                      end else if (over_size) begin
                        res_o.valid  = 1'b1;
                        res_o.status = ST_OVER_SIZE;
                        verdict_d    = 1'b1;
                      end else begin
                        left_d = rec_len;
                        if (rec_q == '0) begin
                          phase_d = PH_MAGIC;
                          magic_d = '0;
                        end else if (rec_len == 16'd0) begin
                          finish = 1'b1;
                        end else begin
                          phase_d = PH_PAYLOAD;
                        end
                      end
                    end
                  endcase
                end
              end
              PH_MAGIC: begin
                off_d  = off_inc;
                bif_d  = bif_inc;
                left_d = left_dec;
                case (bif_q)
                  2'd0: magic_d[7:0]   = data_byte_i;
                  2'd1: magic_d[15:8]  = data_byte_i;
                  2'd2: magic_d[23:16] = data_byte_i;
                  default: begin
                    if (magic_word != cfg_i.expected_magic) begin
                      res_o.valid      = 1'b1;
                      res_o.status     = ST_BAD_MAGIC;
                      res_o.end_offset = off_inc;
                      verdict_d        = 1'b1;
                    end else if (left_dec == 16'd0) begin
                      finish = 1'b1;
                    end else begin
                      phase_d = PH_PAYLOAD;
                    end
                  end
                endcase
              end
              default: begin
                off_d  = off_inc;
                left_d = left_nxt;
                finish = (left_nxt == 16'd0);
              end
            endcase

            // record complete: back to header, check the record limit
            if (finish) begin
              rec_d   = rec_inc;
              phase_d = PH_HEADER;
              hdr_d   = '0;
              bif_d   = '0;
              if (rec_inc >= cfg_i.record_limit) begin
                res_o.valid        = 1'b1;
                res_o.status       = ST_NO_END;
                res_o.end_offset   = off_inc;
                res_o.record_count = rec_inc;
                verdict_d          = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_q     <= '0;
      magic_q   <= '0;
      bif_q     <= '0;
      left_q    <= '0;
      off_q     <= '0;
      rec_q     <= '0;
      verdict_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_q     <= hdr_d;
      magic_q   <= magic_d;
      bif_q     <= bif_d;
      left_q    <= left_d;
      off_q     <= off_d;
      rec_q     <= rec_d;
      verdict_q <= verdict_d;
    end
  end

  a_no_second_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_q && step_i |-> !res_o.valid)
    else $error("verdict given twice in one check");

  a_verdict_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid |=> verdict_q)
    else $error("verdict not recorded");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cmd_i == CMD_START |=> !verdict_q && off_q == '0 && rec_q == '0)
    else $error("start did not clear the check");

  a_payload_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> bif_q == 2'd0)
    else $error("field byte count left over in payload phase");

endmodule

>>> src/tlv_container_checker.sv
// Top level of the TLV container checker: input register, check core, result register.
// Depends on tlvcc_pkg, tlvcc_cfg_regs and tlvcc_core.

// Validates a firmware container fed one byte per word (cmd 1), framed by a start
// word (cmd 0) and an end-of-data word (cmd 2). One word is taken every cycle
// unless the result stalls; a verdict (status, end offset, record count) on the
// word in the input register lands in the result register. The input register and the
// result register both advance whenever the result register is empty or being
// read, so a stalled result holds one pending word and then stops intake.
// After a verdict, data and end words are swallowed until the next start.
// Configuration registers: 0 expected magic, 1 size limit, 2 record limit;
// write them only while no check words are in flight.
module tlv_container_checker import tlvcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [OffW-1:0]   end_offset_o,
  output logic [CountW-1:0] record_count_o
);

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q;
  logic [1:0]        cmd_q;
  logic [7:0]        byte_q;
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [OffW-1:0]   offset_q;
  logic [CountW-1:0] count_q;
  logic              out_free;
  logic              step;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || step;

  tlvcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tlvcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .cmd_i       (cmd_q),
    .data_byte_i (byte_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= step && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      byte_q <= data_byte_i;
    end
    if (step && res.valid) begin
      status_q <= res.status;
      offset_q <= res.end_offset;
      count_q  <= res.record_count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign end_offset_o   = offset_q;
  assign record_count_o = count_q;

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("intake stalled without a blocked result");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(cmd_q) && $stable(byte_q))
    else $error("pending word lost while stalled");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(offset_q) && $stable(count_q))
    else $error("stalled result changed");

endmodule

>>> sim/tlvcc_verdict_checker.sv
// Verdict checker for the TLV container checker: mirrors the byte-serial check,
// queues the verdicts it predicts and compares them with the result channel.
// Depends on tlvcc_pkg.
`timescale 1ns / 1ps

module tlvcc_verdict_checker import tlvcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [2:0]        status_i,
  input  logic [OffW-1:0]   end_offset_i,
  input  logic [CountW-1:0] record_count_i,
  output int                fail_count_o,
  output int                due_count_o
);

  typedef enum logic [1:0] {
    PART_HEADER,
    PART_MAGIC,
    PART_PAYLOAD
  } part_e;

  typedef struct packed {
    status_e           status;
    logic [OffW-1:0]   end_offset;
    logic [CountW-1:0] record_count;
  } verdict_t;

  verdict_t          verdicts_due[$];
  cfg_t              cfg;
  part_e             part;
  logic [31:0]       hdr_word;
  logic [1:0]        byte_idx;
  logic [31:0]       magic_word;
  logic [15:0]       payload_left;
  logic [OffW-1:0]   offset;
  logic [CountW-1:0] records;
  logic              decided;

  task automatic clear_check();
    part         = PART_HEADER;
    hdr_word     = '0;
    byte_idx     = '0;
    magic_word   = '0;
    payload_left = '0;
    offset       = '0;
    records      = '0;
    decided      = 1'b0;
  endtask

  task automatic post_verdict(input status_e st, input logic [OffW-1:0] off);
    verdicts_due.push_back('{status: st, end_offset: off, record_count: records});
    decided = 1'b1;
  endtask

  task automatic bump_offset();
    if (offset != OFFSET_MAX) begin
      offset++;
    end
  endtask

  task automatic close_record();
    records++;
    part     = PART_HEADER;
    hdr_word = '0;
    byte_idx = '0;
    if (records >= cfg.record_limit) begin
      post_verdict(ST_NO_END, offset);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [15:0] rec_type;
    logic [15:0] rec_len;
    if (part == PART_HEADER) begin
      // the record limit is checked before the first byte of a new header
      if (byte_idx == 2'd0 && records >= cfg.record_limit) begin
        post_verdict(ST_NO_END, offset);
      end else begin
        hdr_word[8*byte_idx +: 8] = b;
        bump_offset();
        byte_idx++;
        if (byte_idx == 2'd0) begin
          rec_type = hdr_word[15:0];
          rec_len  = hdr_word[31:16];
          if (records == 0 && (rec_type != FIRST_TYPE || rec_len < MIN_FIRST_LEN)) begin
            post_verdict(ST_BAD_FIRST, offset);
          end else if (rec_type == END_TYPE) begin
            post_verdict(ST_PASS, offset - 24'd4);
          end else if (32'(offset) + 32'(rec_len) > 32'(cfg.size_limit)) begin
            post_verdict(ST_OVER_SIZE, offset);
          end else begin
            payload_left = rec_len;
            if (records == 0) begin
              part       = PART_MAGIC;
              magic_word = '0;
            end else if (rec_len == 16'd0) begin
              close_record();
            end else begin
              part = PART_PAYLOAD;
            end
          end
        end
      end
    end else if (part == PART_MAGIC) begin
      magic_word[8*byte_idx +: 8] = b;
      byte_idx++;
      bump_offset();
      payload_left--;
      if (byte_idx == 2'd0) begin
        if (magic_word != cfg.expected_magic) begin
          post_verdict(ST_BAD_MAGIC, offset);
        end else if (payload_left == 16'd0) begin
          close_record();
        end else begin
          part = PART_PAYLOAD;
        end
      end
    end else begin
      bump_offset();
      if (payload_left != 16'd0) begin
        payload_left--;
      end
      if (payload_left == 16'd0) begin
        close_record();
      end
    end
  endtask

  task automatic predict_verdict(input logic [1:0] c, input logic [7:0] b);
    case (c)
      CMD_START: begin
        clear_check();
      end
      CMD_DATA: begin
        if (!decided) begin
          take_byte(b);
        end
      end
      CMD_END: begin
        // a further header is still owed, even at a record boundary
        if (!decided) begin
          if (part == PART_HEADER && byte_idx == 2'd0 && records >= cfg.record_limit) begin
            post_verdict(ST_NO_END, offset);
          end else begin
            post_verdict(ST_TRUNCATED, offset);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sample mid-cycle: every handshake seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      cfg = '{expected_magic: MAGIC_RST, size_limit: SIZE_RST, record_limit: RECORDS_RST};
      clear_check();
      verdicts_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAGIC:   cfg.expected_magic = cfg_data_i;
          REG_SIZE:    cfg.size_limit     = cfg_data_i[OffW-1:0];
          REG_RECORDS: cfg.record_limit   = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_verdict(cmd_i, data_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict with none due: status %0d, end_offset %0d, record_count %0d",
                 status_i, end_offset_i, record_count_i);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (end_offset_i !== want.end_offset) begin
            $error("end_offset: expected %0d, actual %0d", want.end_offset, end_offset_i);
            fail_count_o++;
          end
          if (record_count_i !== want.record_count) begin
            $error("record_count: expected %0d, actual %0d",
                   want.record_count, record_count_i);
            fail_count_o++;
          end
        end
      end
    end
    due_count_o = verdicts_due.size();
  end

endmodule

>>> sim/tb_tlv_container_checker.sv
// Testbench top for the TLV container checker: clock, reset, register writes and
// container streams under random stalls; the verdict checker does the comparing.
// Depends on tlvcc_pkg, tlv_container_checker and tlvcc_verdict_checker.
`timescale 1ns / 1ps

module tb_tlv_container_checker;
  import tlvcc_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASES       = 6;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [31:0] ALT_MAGIC    = 32'h43424d4d;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index   = REG_MAGIC;
  logic [31:0]       cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [1:0]        cmd         = CMD_START;
  logic [7:0]        data_byte   = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [2:0]        status;
  logic [OffW-1:0]   end_offset;
  logic [CountW-1:0] record_count;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                words_sent    = 0;
  int                cycle_cnt     = 0;
  int                fail_cnt;
  int                due_cnt;
  logic [31:0]       cur_magic     = MAGIC_RST;

  always #5 clk = ~clk;

  tlv_container_checker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .end_offset_o   (end_offset),
    .record_count_o (record_count)
  );

  tlvcc_verdict_checker verdict_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .end_offset_i   (end_offset),
    .record_count_i (record_count),
    .fail_count_o   (fail_cnt),
    .due_count_o    (due_cnt)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold the word until it is taken; ready is sampled mid-cycle.
  task automatic push_word(input logic [1:0] c, input logic [7:0] b);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    words_sent++;
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Drop valid, wait for every due verdict, then let in-flight words settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (due_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [OffW-1:0] size_lim,
                            input logic [CountW-1:0] rec_lim);
    wait_idle();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_SIZE, 32'(size_lim));
    write_reg(REG_RECORDS, 32'(rec_lim));
    cfg_valid <= 1'b0;
    cur_magic = magic;
  endtask

  // One framed container: start, bytes (with stray unused words), end of data.
  task automatic send_container();
    logic [7:0]  img[$];
    logic [31:0] magic;
    logic [15:0] typ;
    logic [15:0] len;
    int          flaw;
    int          nrec;
    int          body;
    flaw  = $urandom_range(99);
    magic = cur_magic;
    typ   = FIRST_TYPE;
    len   = 16'($urandom_range(4, 12));
    // below 55 clean; then wrong magic, bad first header, cut short,
    // oversized first record, missing end marker; 90 and up clean again
    if (flaw >= 55 && flaw < 63) begin
      magic ^= 32'd1 << $urandom_range(31);
    end
    if (flaw >= 63 && flaw < 69) begin
      if ($urandom_range(1) == 0) begin
        typ = 16'($urandom);
        if (typ == FIRST_TYPE) begin
          typ = END_TYPE;
        end
      end else begin
        len = 16'($urandom_range(3));
      end
    end
    if (flaw >= 77 && flaw < 83) begin
      len = 16'($urandom_range(16'h0100, 16'hFFFF));
    end
    nrec = $urandom_range(4);
    for (int r = 0; r <= nrec; r++) begin
      if (r > 0) begin
        typ = 16'($urandom);
        len = 16'($urandom_range(10));
      end
      img.push_back(typ[7:0]);
      img.push_back(typ[15:8]);
      img.push_back(len[7:0]);
      img.push_back(len[15:8]);
      // long records only get a short stretch of their payload
      body = (len > 16) ? $urandom_range(4, 16) : int'(len);
      for (int i = 0; i < body; i++) begin
        img.push_back((r == 0 && i < 4) ? magic[8*i +: 8] : 8'($urandom));
      end
    end
    if (!(flaw >= 83 && flaw < 90)) begin
      img.push_back(END_TYPE[7:0]);
      img.push_back(END_TYPE[15:8]);
      img.push_back(8'($urandom));
      img.push_back(8'($urandom));
    end
    repeat ($urandom_range(2)) img.push_back(8'($urandom));
    if (flaw >= 69 && flaw < 77) begin
      body = $urandom_range(img.size() - 1);
      while (img.size() > body) void'(img.pop_back());
    end
    push_word(CMD_START, 8'($urandom));
    foreach (img[i]) begin
      if ($urandom_range(99) < 3) begin
        push_word(CMD_UNUSED, 8'($urandom));
      end
      push_word(CMD_DATA, img[i]);
    end
    push_word(CMD_END, 8'($urandom));
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL tlv_container_checker");
    $finish;
  end

  initial begin
    logic [7:0] first_rec[$];
    int         goal;
    logic [31:0]       ph_magic;
    logic [OffW-1:0]   ph_size;
    logic [CountW-1:0] ph_recs;

    first_rec = '{FIRST_TYPE[7:0], FIRST_TYPE[15:8], MIN_FIRST_LEN[7:0], MIN_FIRST_LEN[15:8],
                  MAGIC_RST[7:0], MAGIC_RST[15:8], MAGIC_RST[23:16], MAGIC_RST[31:24]};
    send_idle_pct = 33;
    recv_idle_pct = 80;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes before any start, then end at a record boundary: truncated
    foreach (first_rec[i]) push_word(CMD_DATA, first_rec[i]);
    push_word(CMD_END, 8'h00);
    // swallowed after the verdict
    push_word(CMD_DATA, 8'hFF);
    push_word(CMD_UNUSED, 8'hFF);
    // minimal passing container
    push_word(CMD_START, 8'h00);
    foreach (first_rec[i]) push_word(CMD_DATA, first_rec[i]);
    push_word(CMD_DATA, END_TYPE[7:0]);
    push_word(CMD_DATA, END_TYPE[15:8]);
    push_word(CMD_DATA, 8'hFF);
    push_word(CMD_DATA, 8'hFF);
    push_word(CMD_END, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ph_magic = $urandom;   ph_size = SIZE_RST;  ph_recs = 9'd8;   end
        1: begin ph_magic = 32'h0;      ph_size = 24'd4;     ph_recs = 9'd1;   end
        2: begin ph_magic = '1;         ph_size = 24'd8388608; ph_recs = 9'd256; end
        3: begin ph_magic = $urandom;   ph_size = 24'd24;    ph_recs = 9'd0;   end
        4: begin
          ph_magic = ALT_MAGIC;
          ph_size  = 24'($urandom_range(40, 400));
          ph_recs  = 9'd3;
        end
        default: begin
          ph_magic = $urandom;
          ph_size  = 24'($urandom_range(64, 8388608));
          ph_recs  = 9'($urandom_range(1, 16));
        end
      endcase
      set_config(ph_magic, ph_size, ph_recs);
      if (p == 2) begin
        send_idle_pct = 80;
        recv_idle_pct = 33;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      goal = words_sent + ((p == 1 || p == 3) ? 60 : (p == 5 ? 150 : 260));
      while (words_sent < goal) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(4, 16)) push_word(2'($urandom_range(3)), 8'($urandom));
        end else begin
          send_container();
        end
      end
    end

    wait_idle();
    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("PASS tlv_container_checker");
    end else begin
      $display("FAIL tlv_container_checker");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tlvcc_pkg.sv
src/tlvcc_cfg_regs.sv
src/tlvcc_core.sv
src/tlv_container_checker.sv
sim/tlvcc_verdict_checker.sv
sim/tb_tlv_container_checker.sv
